>>> design/geo_grid_bilinear_sampler_unit_macros.svh
// Assertion macros for the elevation grid sampler checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef GEO_GRID_BILINEAR_SAMPLER_UNIT_MACROS_SVH
`define GEO_GRID_BILINEAR_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define GGBS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// Next-cycle implication, disabled while in reset.
`define GGBS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

>>> design/ggbs_pkg.sv
// Shared types and constants for the elevation grid sampler.
// No dependencies; the design files that use it refer to it by scoped names.
package ggbs_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;

    localparam int COL_IDX_BITS = $clog2(MAX_COLUMNS);
    localparam int ROW_IDX_BITS = $clog2(MAX_ROWS);
    localparam int GRID_DEPTH   = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_BITS    = $clog2(GRID_DEPTH);

    localparam logic [ADDR_BITS-1:0] COL_STRIDE = ADDR_BITS'(MAX_COLUMNS);

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_LON  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ORIGIN_LAT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PPD_X       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PPD_Y       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_COLS_IN_USE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROWS_IN_USE = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_NODATA_IN   = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_NODATA_OUT  = 3'd7;

    // Operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic       capture;
        logic       load_write;
        logic       diff_en;
        logic       mul_en;
        logic       mul_y;
        logic       check_x;
        logic       check_y;
        logic       rd_en;
        logic [1:0] sel;
        logic       term_en;
        logic       acc_clr;
        logic       acc_en;
        logic       out_load;
    } ggbs_cmd_t;

    typedef struct packed {
        logic in_range;
    } ggbs_stat_t;

endpackage

>>> design/ggbs_req_if.sv
// Request channel (load or query) for the elevation grid sampler.
// Standalone interface; no package dependency.
interface ggbs_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  load_column;
    logic [7:0]  load_row;
    logic [31:0] load_elevation;
    logic [31:0] query_latitude;
    logic [31:0] query_longitude;

    modport source (
        output valid, operation, load_column, load_row, load_elevation,
               query_latitude, query_longitude,
        input  ready
    );
    modport sink (
        input  valid, operation, load_column, load_row, load_elevation,
               query_latitude, query_longitude,
        output ready
    );
endinterface

>>> design/ggbs_res_if.sv
// Result channel of the elevation grid sampler.
// Standalone interface; no package dependency.
interface ggbs_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] sampled_elevation;
    logic        out_of_range;

    modport source (output valid, sampled_elevation, out_of_range, input ready);
    modport sink   (input valid, sampled_elevation, out_of_range, output ready);
endinterface

>>> design/geo_grid_bilinear_sampler_unit.sv
// Top level of the elevation grid sampler: controller plus datapath.
// Depends on ggbs_pkg, ggbs_req_if, ggbs_res_if, ggbs_ctrl, ggbs_datapath.
//
//   channel   dir   contents
//   req_ch    in    operation, load cell (column, row, elevation), query lat/lon
//   res_ch    out   sampled_elevation, out_of_range
//   cfg       in    cfg_we, cfg_index, cfg_data (write only)
//
// A load is written while the controller is idle; the next request can be taken in the following cycle.
// An in-range query holds the request channel through diff, two passes of the
// shared 33x32 multiplier, range check, four grid RAM reads, a drain and the result load.
// An out-of-range query skips the reads and the drain.
// The result load stalls while the previous result still waits for res_ch.ready.
// Grid contents are not cleared by reset; read only cells that were loaded.
module geo_grid_bilinear_sampler_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    ggbs_req_if.sink                           req_ch,
    ggbs_res_if.source                         res_ch,
    input  logic                               cfg_we,
    input  logic [ggbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ggbs_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    ggbs_pkg::ggbs_cmd_t  cmd;
    ggbs_pkg::ggbs_stat_t stat;

    ggbs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_ch.valid),
        .req_operation (req_ch.operation),
        .req_ready     (req_ch.ready),
        .res_ready     (res_ch.ready),
        .res_valid     (res_ch.valid),
        .stat          (stat),
        .cmd           (cmd)
    );

    ggbs_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .load_column       (req_ch.load_column),
        .load_row          (req_ch.load_row),
        .load_elevation    (req_ch.load_elevation),
        .query_latitude    (req_ch.query_latitude),
        .query_longitude   (req_ch.query_longitude),
        .cmd               (cmd),
        .stat              (stat),
        .sampled_elevation (res_ch.sampled_elevation),
        .out_of_range      (res_ch.out_of_range)
    );

endmodule

>>> design/ggbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ggbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/ggbs_ctrl.sv
// Controller state machine: accepts loads and sequences query mapping, cell reads and blend.
// Depends on ggbs_pkg for the command and status types.
module ggbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_operation,
    output logic                req_ready,
    input  logic                res_ready,
    output logic                res_valid,
    input  ggbs_pkg::ggbs_stat_t stat,
    output ggbs_pkg::ggbs_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DIFF   = 3'd1;
    localparam logic [2:0] S_MULX   = 3'd2;
    localparam logic [2:0] S_MULY   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_DRAIN  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       term_v_reg, acc_v_reg;
    logic       res_valid_reg, res_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        cmd.term_en = term_v_reg;
        cmd.acc_en  = acc_v_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid && req_operation == ggbs_pkg::OP_QUERY)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DIFF;
                end
                else if (req_valid && req_operation == ggbs_pkg::OP_LOAD)
                begin
                    cmd.load_write = 1'b1;
                end
            end
            S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                state_next  = S_MULX;
            end
            S_MULX:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_MULY;
            end
            S_MULY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_y   = 1'b1;
                cmd.check_x = 1'b1;
                state_next  = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check_y = 1'b1;
                cmd.acc_clr = 1'b1;
                cnt_next    = 2'd0;
                state_next  = stat.in_range ? S_READ : S_FINISH;
            end
            S_READ:
            begin
                cmd.rd_en = 1'b1;
                cmd.sel   = cnt_reg;
                cnt_next  = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // wait for the last product and its accumulation
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd1)
                begin
                    cnt_next   = 2'd0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.out_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 2'd0;
            term_v_reg    <= 1'b0;
            acc_v_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            term_v_reg    <= cmd.rd_en;
            acc_v_reg     <= term_v_reg;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule

>>> design/ggbs_datapath.sv
// Datapath: configuration registers, pixel mapping, grid RAM and blend.
// Depends on ggbs_pkg and ggbs_ram.
module ggbs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ggbs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [ggbs_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [7:0]                          load_column,
    input  logic [7:0]                          load_row,
    input  logic [31:0]                         load_elevation,
    input  logic [31:0]                         query_latitude,
    input  logic [31:0]                         query_longitude,
    input  ggbs_pkg::ggbs_cmd_t                 cmd,
    output ggbs_pkg::ggbs_stat_t                stat,
    output logic [31:0]                         sampled_elevation,
    output logic                                out_of_range
);

    logic [31:0] org_lon_reg, org_lat_reg, ppd_x_reg, ppd_y_reg;
    logic [8:0]  cols_reg, rows_reg;
    logic [31:0] nodata_in_reg, nodata_out_reg;

    logic [31:0] lat_reg, lon_reg;
    logic [32:0] mdx_reg, mdy_reg;
    logic        ndx_reg, ndy_reg;
    logic [31:0] msx_reg, msy_reg;
    logic        nsx_reg, nsy_reg;
    logic [63:0] prod_reg;

    logic [ggbs_pkg::COL_IDX_BITS-1:0] x0_reg;
    logic [ggbs_pkg::ROW_IDX_BITS-1:0] y0_reg;
    logic [15:0] dx_reg, dy_reg;
    logic        okx_reg, oor_reg;

    logic [32:0] weight_reg;
    logic [63:0] term_reg, acc_reg;
    logic [31:0] out_elev_reg;
    logic        out_oor_reg;

    logic [32:0] dlon, dlat;
    logic [32:0] mul_a;
    logic [31:0] mul_b;
    logic        okx, oky;
    logic [16:0] wx, wy;
    logic [ggbs_pkg::COL_IDX_BITS-1:0] rd_col;
    logic [ggbs_pkg::ROW_IDX_BITS-1:0] rd_row;
    logic [ggbs_pkg::ADDR_BITS-1:0]    raddr, waddr;
    logic [31:0] wdata, rdata;
    logic        load_in_grid;
    logic [63:0] rounded;

    // Checks one mapped axis against the usable extent.
    function automatic logic axis_ok(input logic [63:0] prod, input logic nd,
                                     input logic ns, input logic [8:0] count,
                                     input int max_count);
        logic [12:0] cnt;
        logic [25:0] ip;
        cnt = (32'(count) > max_count) ? 13'(max_count) : 13'(count);
        ip  = prod[63:38];
        return !(prod != 64'd0 && nd != ns) && cnt >= 13'd2
               && ip < 26'(cnt - 13'd1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_lon_reg    <= 32'd0;
            org_lat_reg    <= 32'd0;
            ppd_x_reg      <= 32'h0001_0000;
            ppd_y_reg      <= 32'hFFFF_0000;
            cols_reg       <= 9'd256;
            rows_reg       <= 9'd256;
            nodata_in_reg  <= 32'h8000_0000;
            nodata_out_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ggbs_pkg::REG_ORIGIN_LON:  org_lon_reg    <= cfg_data;
                ggbs_pkg::REG_ORIGIN_LAT:  org_lat_reg    <= cfg_data;
                ggbs_pkg::REG_PPD_X:       ppd_x_reg      <= cfg_data;
                ggbs_pkg::REG_PPD_Y:       ppd_y_reg      <= cfg_data;
                ggbs_pkg::REG_COLS_IN_USE: cols_reg       <= cfg_data[8:0];
                ggbs_pkg::REG_ROWS_IN_USE: rows_reg       <= cfg_data[8:0];
                ggbs_pkg::REG_NODATA_IN:   nodata_in_reg  <= cfg_data;
                ggbs_pkg::REG_NODATA_OUT:  nodata_out_reg <= cfg_data;
                default:                   org_lon_reg    <= org_lon_reg;
            endcase
        end
    end

    // Load path: a nodata code is stored as zero.
    assign load_in_grid = (32'(load_column) < ggbs_pkg::MAX_COLUMNS)
                          && (32'(load_row) < ggbs_pkg::MAX_ROWS);
    assign waddr = ggbs_pkg::ADDR_BITS'(ggbs_pkg::ADDR_BITS'(load_row)
                   * ggbs_pkg::COL_STRIDE) + ggbs_pkg::ADDR_BITS'(load_column);
    assign wdata = (load_elevation == nodata_in_reg) ? 32'd0 : load_elevation;

    assign dlon = {lon_reg[31], lon_reg} - {org_lon_reg[31], org_lon_reg};
    assign dlat = {lat_reg[31], lat_reg} - {org_lat_reg[31], org_lat_reg};

    assign mul_a = cmd.mul_y ? mdy_reg : mdx_reg;
    assign mul_b = cmd.mul_y ? msy_reg : msx_reg;

    assign okx = axis_ok(prod_reg, ndx_reg, nsx_reg, cols_reg, ggbs_pkg::MAX_COLUMNS);
    assign oky = axis_ok(prod_reg, ndy_reg, nsy_reg, rows_reg, ggbs_pkg::MAX_ROWS);
    assign stat.in_range = okx_reg && oky;

    // Cell select: bit 0 steps the column, bit 1 steps the row.
    assign wx = cmd.sel[0] ? {1'b0, dx_reg} : 17'h1_0000 - {1'b0, dx_reg};
    assign wy = cmd.sel[1] ? {1'b0, dy_reg} : 17'h1_0000 - {1'b0, dy_reg};
    assign rd_col = x0_reg + ggbs_pkg::COL_IDX_BITS'(cmd.sel[0]);
    assign rd_row = y0_reg + ggbs_pkg::ROW_IDX_BITS'(cmd.sel[1]);
    assign raddr  = ggbs_pkg::ADDR_BITS'(ggbs_pkg::ADDR_BITS'(rd_row)
                    * ggbs_pkg::COL_STRIDE) + ggbs_pkg::ADDR_BITS'(rd_col);

    assign rounded = acc_reg + 64'h0000_0000_8000_0000;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            lat_reg <= query_latitude;
            lon_reg <= query_longitude;
        end
        if (cmd.diff_en)
        begin
            ndx_reg <= dlon[32];
            ndy_reg <= dlat[32];
            mdx_reg <= dlon[32] ? 33'd0 - dlon : dlon;
            mdy_reg <= dlat[32] ? 33'd0 - dlat : dlat;
            nsx_reg <= ppd_x_reg[31];
            nsy_reg <= ppd_y_reg[31];
            msx_reg <= ppd_x_reg[31] ? 32'd0 - ppd_x_reg : ppd_x_reg;
            msy_reg <= ppd_y_reg[31] ? 32'd0 - ppd_y_reg : ppd_y_reg;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= {31'd0, mul_a} * {32'd0, mul_b};
        end
        if (cmd.check_x)
        begin
            okx_reg <= okx;
            x0_reg  <= prod_reg[38 +: ggbs_pkg::COL_IDX_BITS];
            dx_reg  <= prod_reg[37:22];
        end
        if (cmd.check_y)
        begin
            oor_reg <= !(okx_reg && oky);
            y0_reg  <= prod_reg[38 +: ggbs_pkg::ROW_IDX_BITS];
            dy_reg  <= prod_reg[37:22];
        end
        if (cmd.rd_en)
        begin
            weight_reg <= 33'({17'd0, wx} * {17'd0, wy});
        end
        if (cmd.term_en)
        begin
            term_reg <= {{32{rdata[31]}}, rdata} * {31'd0, weight_reg};
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= 64'd0;
        end
        else if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + term_reg;
        end
        if (cmd.out_load)
        begin
            out_elev_reg <= oor_reg ? nodata_out_reg : rounded[63:32];
            out_oor_reg  <= oor_reg;
        end
    end

    ggbs_ram #(
        .WIDTH (32),
        .DEPTH (ggbs_pkg::GRID_DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (cmd.load_write && load_in_grid),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sampled_elevation = out_elev_reg;
    assign out_of_range      = out_oor_reg;

endmodule

>>> design/ggbs_checker.sv
// Port-level checker for the elevation grid sampler, bound to the top level.
// Depends on ggbs_pkg and the assertion macro header.
`include "geo_grid_bilinear_sampler_unit_macros.svh"

module ggbs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        req_operation,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] res_elev,
    input logic        res_oor
);

    logic query_acc;
    assign query_acc = req_valid && req_ready && req_operation == ggbs_pkg::OP_QUERY;

    `GGBS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
    `GGBS_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(res_elev) && $stable(res_oor))
    `GGBS_ASSERT_NEXT(a_query_busy, query_acc, !req_ready)
    `GGBS_ASSERT_NEXT(a_no_instant_result, query_acc && !res_valid, !res_valid)

endmodule

bind geo_grid_bilinear_sampler_unit ggbs_checker u_ggbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_operation (req_ch.operation),
    .res_valid     (res_ch.valid),
    .res_ready     (res_ch.ready),
    .res_elev      (res_ch.sampled_elevation),
    .res_oor       (res_ch.out_of_range)
);

>>> bench/ggbs_scoreboard.sv
// Scoreboard for the elevation grid sampler: tracks the grid and the register
// file, predicts each query's sample and compares the results in order.
// Depends on ggbs_pkg, ggbs_req_if and ggbs_res_if.
`timescale 1ns / 1ps

module ggbs_scoreboard (
    input  logic                               clk,
    input  logic                               rst_n,
    ggbs_req_if                                req_mon,
    ggbs_res_if                                res_mon,
    input  logic                               cfg_we,
    input  logic [ggbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ggbs_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                 mismatch_count,
    output int                                 pending_results
);

    typedef struct {
        bit [31:0] elevation;
        bit        outside;
    } sample_t;

    bit [31:0] grid_mem [0:ggbs_pkg::GRID_DEPTH-1];
    bit [31:0] lon_base, lat_base, scale_x, scale_y;
    bit [31:0] nodata_in, nodata_out;
    bit [8:0]  col_count, row_count;
    sample_t   expected_samples [$];
    int        errors;

    // Map one axis to a cell index and a Q0.16 fraction; 0 when off the grid.
    function automatic bit locate_axis(bit [31:0] coord, bit [31:0] origin,
                                       bit [31:0] scale, bit [8:0] count_raw,
                                       int max_count,
                                       output int idx, output bit [15:0] frac);
        longint    delta;
        longint    sc;
        bit [63:0] dmag, smag, prod;
        int        count;
        delta = longint'(signed'(coord)) - longint'(signed'(origin));
        sc    = longint'(signed'(scale));
        dmag  = (delta < 0) ? -delta : delta;
        smag  = (sc < 0) ? -sc : sc;
        prod  = dmag * smag;
        count = (count_raw > max_count) ? max_count : int'(count_raw);
        idx   = int'(prod >> 38);
        frac  = prod[37:22];
        if (prod != 0 && ((delta < 0) != (sc < 0)))
            return 1'b0;
        return count >= 2 && (prod >> 38) < 64'(count - 1);
    endfunction

    function automatic longint cell_at(int col, int row);
        return longint'(signed'(grid_mem[row * ggbs_pkg::MAX_COLUMNS + col]));
    endfunction

    function automatic sample_t sample_grid(bit [31:0] lat, bit [31:0] lon);
        sample_t   s;
        int        x0, y0;
        bit [15:0] dx, dy;
        longint    wx0, wx1, wy0, wy1, total;
        bit [63:0] rounded;
        bit        in_x, in_y;
        in_x = locate_axis(lon, lon_base, scale_x, col_count, ggbs_pkg::MAX_COLUMNS, x0, dx);
        in_y = locate_axis(lat, lat_base, scale_y, row_count, ggbs_pkg::MAX_ROWS, y0, dy);
        if (!(in_x && in_y))
        begin
            s.elevation = nodata_out;
            s.outside   = 1'b1;
            return s;
        end
        wx1 = dx;
        wx0 = 65536 - wx1;
        wy1 = dy;
        wy0 = 65536 - wy1;
        total = cell_at(x0, y0) * (wx0 * wy0) + cell_at(x0 + 1, y0) * (wx1 * wy0)
              + cell_at(x0, y0 + 1) * (wx0 * wy1)
              + cell_at(x0 + 1, y0 + 1) * (wx1 * wy1);
        // round half up, then drop the 32 weight fraction bits
        rounded     = total + 64'h8000_0000;
        s.elevation = rounded[63:32];
        s.outside   = 1'b0;
        return s;
    endfunction

    function automatic void note_mismatch(string what, bit [31:0] want, bit [31:0] got);
        if (errors < 10)
            $display("%0t: %s expected %h got %h", $realtime, what, want, got);
        errors++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n)
        begin
            lon_base   = 0;
            lat_base   = 0;
            scale_x    = 32'h0001_0000;
            scale_y    = 32'hFFFF_0000;
            col_count  = 9'd256;
            row_count  = 9'd256;
            nodata_in  = 32'h8000_0000;
            nodata_out = 0;
            expected_samples.delete();
            errors = 0;
            mismatch_count  <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ggbs_pkg::REG_ORIGIN_LON:  lon_base   = cfg_data;
                    ggbs_pkg::REG_ORIGIN_LAT:  lat_base   = cfg_data;
                    ggbs_pkg::REG_PPD_X:       scale_x    = cfg_data;
                    ggbs_pkg::REG_PPD_Y:       scale_y    = cfg_data;
                    ggbs_pkg::REG_COLS_IN_USE: col_count  = cfg_data[8:0];
                    ggbs_pkg::REG_ROWS_IN_USE: row_count  = cfg_data[8:0];
                    ggbs_pkg::REG_NODATA_IN:   nodata_in  = cfg_data;
                    ggbs_pkg::REG_NODATA_OUT:  nodata_out = cfg_data;
                    default: ;
                endcase
            end
            if (req_mon.valid && req_mon.ready)
            begin
                if (req_mon.operation == ggbs_pkg::OP_LOAD)
                    grid_mem[{req_mon.load_row, req_mon.load_column}] =
                        (req_mon.load_elevation == nodata_in) ? 32'd0 : req_mon.load_elevation;
                else
                    expected_samples.push_back(
                        sample_grid(req_mon.query_latitude, req_mon.query_longitude));
            end
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_samples.size() == 0)
                    note_mismatch("unexpected result, elevation", 0, res_mon.sampled_elevation);
                else
                begin
                    want = expected_samples.pop_front();
                    if (res_mon.sampled_elevation !== want.elevation)
                        note_mismatch("sampled_elevation", want.elevation,
                                      res_mon.sampled_elevation);
                    if (res_mon.out_of_range !== want.outside)
                        note_mismatch("out_of_range", 32'(want.outside),
                                      32'(res_mon.out_of_range));
                end
            end
            mismatch_count  <= errors;
            pending_results <= expected_samples.size();
        end
    end
endmodule

>>> bench/geo_grid_bilinear_sampler_unit_test.sv
// Top of the elevation grid sampler bench: loads cells, issues queries over a
// series of register settings and gives the verdict from the scoreboard.
// Depends on ggbs_pkg, the channel interfaces, the block and ggbs_scoreboard.
`timescale 1ns / 1ps

module geo_grid_bilinear_sampler_unit_test;

    localparam int ITEM_TARGET = 1050;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [ggbs_pkg::CFG_IDX_BITS-1:0]  cfg_index;
    logic [ggbs_pkg::CFG_DATA_BITS-1:0] cfg_data;
    int                                 mismatch_count;
    int                                 pending_results;

    ggbs_req_if req_ch ();
    ggbs_res_if res_ch ();

    geo_grid_bilinear_sampler_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .res_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ggbs_scoreboard checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_mon         (req_ch),
        .res_mon         (res_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    bit [31:0] reg_copy [0:7];
    bit        loaded [0:ggbs_pkg::GRID_DEPTH-1];
    int        items_sent;
    int        burst_left;
    int        stall_mode;
    int        mode_left;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: switch between free flow, random and heavy stalls.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 120);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       res_ch.ready <= 1'b1;
            1:       res_ch.ready <= 1'($urandom_range(0, 1));
            2:       res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Cell index on one axis, used to preload the cells a query will read.
    function automatic bit axis_cell(bit [31:0] coord, bit [31:0] origin, bit [31:0] scale,
                                     bit [31:0] count_raw, output int idx);
        longint    delta, sc;
        bit [63:0] prod;
        int        count;
        delta = longint'(signed'(coord)) - longint'(signed'(origin));
        sc    = longint'(signed'(scale));
        prod  = 64'((delta < 0) ? -delta : delta) * 64'((sc < 0) ? -sc : sc);
        count = (count_raw[8:0] > 256) ? 256 : int'(count_raw[8:0]);
        idx   = int'(prod >> 38);
        return !(prod != 0 && ((delta < 0) != (sc < 0))) && count >= 2
               && (prod >> 38) < 64'(count - 1);
    endfunction

    // Coordinate that lands near a chosen cell, sometimes just past the edge.
    function automatic bit [31:0] aim_axis(bit [31:0] origin, bit [31:0] scale,
                                           bit [31:0] count_raw);
        longint    sc;
        bit [63:0] target, step;
        int        count;
        count  = (count_raw[8:0] > 256) ? 256 : int'(count_raw[8:0]);
        target = (64'($urandom_range(0, (count < 2) ? 2 : count - 1)) << 38)
               | ({$urandom, $urandom} & 64'h3F_FFFF_FFFF);
        sc     = longint'(signed'(scale));
        if (sc == 0)
            return origin + $urandom_range(0, 1 << 20) - (1 << 19);
        step = target / 64'((sc < 0) ? -sc : sc);
        return (sc < 0) ? origin - step[31:0] : origin + step[31:0];
    endfunction

    // Drive one request and hold it until accepted; returns at the accept edge.
    task automatic send_request(logic op, bit [7:0] col, bit [7:0] row, bit [31:0] elev,
                                bit [31:0] lat, bit [31:0] lon);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 14);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid           <= 1'b1;
        req_ch.operation       <= op;
        req_ch.load_column     <= col;
        req_ch.load_row        <= row;
        req_ch.load_elevation  <= elev;
        req_ch.query_latitude  <= lat;
        req_ch.query_longitude <= lon;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic load_cell(bit [7:0] col, bit [7:0] row, bit [31:0] elev);
        send_request(ggbs_pkg::OP_LOAD, col, row, elev, $urandom, $urandom);
        loaded[{row, col}] = 1'b1;
    endtask

    // Load any of the four cells not yet written, then issue the query.
    task automatic query_at(bit [31:0] lat, bit [31:0] lon);
        int x0, y0;
        if (axis_cell(lon, reg_copy[ggbs_pkg::REG_ORIGIN_LON], reg_copy[ggbs_pkg::REG_PPD_X],
                      reg_copy[ggbs_pkg::REG_COLS_IN_USE], x0)
            && axis_cell(lat, reg_copy[ggbs_pkg::REG_ORIGIN_LAT], reg_copy[ggbs_pkg::REG_PPD_Y],
                         reg_copy[ggbs_pkg::REG_ROWS_IN_USE], y0))
        begin
            for (int j = 0; j < 4; j++)
                if (!loaded[(y0 + j / 2) * ggbs_pkg::MAX_COLUMNS + x0 + j % 2])
                    load_cell(8'(x0 + j % 2), 8'(y0 + j / 2), $urandom);
        end
        send_request(ggbs_pkg::OP_QUERY, 8'($urandom), 8'($urandom), $urandom, lat, lon);
    endtask

    // Drop valid and hold until every sample is back.
    task automatic drain_results;
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [ggbs_pkg::CFG_IDX_BITS-1:0] idx, bit [31:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        reg_copy[idx] = data;
    endtask

    task automatic apply_setting(bit [31:0] lon0, bit [31:0] lat0, bit [31:0] sx,
                                 bit [31:0] sy, bit [31:0] cols, bit [31:0] rows,
                                 bit [31:0] nd_in, bit [31:0] nd_out);
        drain_results();
        repeat (14) @(posedge clk);
        write_reg(ggbs_pkg::REG_ORIGIN_LON, lon0);
        write_reg(ggbs_pkg::REG_ORIGIN_LAT, lat0);
        write_reg(ggbs_pkg::REG_PPD_X, sx);
        write_reg(ggbs_pkg::REG_PPD_Y, sy);
        write_reg(ggbs_pkg::REG_COLS_IN_USE, cols);
        write_reg(ggbs_pkg::REG_ROWS_IN_USE, rows);
        write_reg(ggbs_pkg::REG_NODATA_IN, nd_in);
        write_reg(ggbs_pkg::REG_NODATA_OUT, nd_out);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic bit [31:0] pick_scale();
        bit [31:0] mag;
        case ($urandom_range(0, 5))
            0:       mag = $urandom;
            1:       mag = $urandom_range(1, 1 << 16);
            default: mag = $urandom_range(1 << 14, 1 << 24);
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    function automatic bit [31:0] pick_count();
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 511);
            1:       return 256;
            default: return $urandom_range(2, 16);
        endcase
    endfunction

    task automatic random_phase(int count);
        bit [31:0] lat, lon, elev;
        for (int k = 0; k < count; k++)
        begin
            if (k == count / 2)
                drain_results();
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5:
                begin
                    elev = ($urandom_range(0, 9) == 0) ? reg_copy[ggbs_pkg::REG_NODATA_IN]
                                                        : $urandom;
                    load_cell(8'($urandom), 8'($urandom), elev);
                end
                6, 7, 8:
                    query_at($urandom, $urandom);
                default:
                begin
                    lat = aim_axis(reg_copy[ggbs_pkg::REG_ORIGIN_LAT],
                                   reg_copy[ggbs_pkg::REG_PPD_Y],
                                   reg_copy[ggbs_pkg::REG_ROWS_IN_USE]);
                    lon = aim_axis(reg_copy[ggbs_pkg::REG_ORIGIN_LON],
                                   reg_copy[ggbs_pkg::REG_PPD_X],
                                   reg_copy[ggbs_pkg::REG_COLS_IN_USE]);
                    query_at(lat, lon);
                end
            endcase
        end
    endtask

    initial
    begin
        int wait_cycles;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.operation       = ggbs_pkg::OP_LOAD;
        req_ch.load_column     = '0;
        req_ch.load_row        = '0;
        req_ch.load_elevation  = '0;
        req_ch.query_latitude  = '0;
        req_ch.query_longitude = '0;
        res_ch.ready = 1'b0;
        items_sent   = 0;
        burst_left   = 0;
        reg_copy = '{32'd0, 32'd0, 32'h0001_0000, 32'hFFFF_0000,
                     32'd256, 32'd256, 32'h8000_0000, 32'd0};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one pixel per degree, latitude axis flipped.
        load_cell(8'd0, 8'd0, 32'h7FFF_FFFF);
        load_cell(8'd1, 8'd0, 32'h8000_0000);  // nodata input code, stored as zero
        load_cell(8'd0, 8'd1, 32'hFFFF_FFFF);
        load_cell(8'd1, 8'd1, 32'h0000_0001);
        load_cell(8'd255, 8'd255, 32'h1234_5678);
        query_at(32'd0, 32'd0);
        query_at(-(32'd3 << 21), 32'd3 << 21);
        query_at(-(32'd1 << 21), 32'd1 << 21);
        query_at(32'd1 << 21, 32'd1 << 21);          // positive latitude: out of range
        query_at(-(32'd1 << 21), -(32'd1 << 21));    // negative column: out of range
        query_at(32'h8000_0000, 32'h7FFF_FFFF);
        query_at(32'h7FFF_FFFF, 32'h8000_0000);
        query_at(-(32'd254 << 22), 32'd254 << 22);   // last usable cell
        query_at(-(32'd255 << 22), 32'd255 << 22);   // edge cell: out of range

        // Extreme scales, then zero scale with extreme origins.
        apply_setting(0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 256, 256,
                      32'h7FFF_FFFF, 32'h8000_0000);
        load_cell(8'd3, 8'd3, 32'h7FFF_FFFF);
        random_phase(40);
        apply_setting(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 2, 2, 0, 32'h7FFF_FFFF);
        load_cell(8'd0, 8'd0, 32'd0);
        query_at(32'h8000_0000, 32'h7FFF_FFFF);
        random_phase(40);
        // Counts below two: everything off the grid.
        apply_setting($urandom, $urandom, 1, -1, 0, 1, $urandom, $urandom);
        random_phase(40);
        // Counts beyond the grid saturate.
        apply_setting($urandom, $urandom, 3600 << 16, -(3600 << 16), 511, 300,
                      32'hFFFF_FFFF, 32'hDEAD_BEEF);
        random_phase(60);
        apply_setting(0, 0, 1 << 16, 1 << 16, 256, 2, 0, 32'h8000_0000);
        random_phase(60);

        while (items_sent < ITEM_TARGET)
        begin
            apply_setting($urandom, $urandom, pick_scale(), pick_scale(), pick_count(),
                          pick_count(), $urandom_range(0, 1) ? 32'd0 : $urandom, $urandom);
            random_phase(30);
        end

        req_ch.valid <= 1'b0;
        wait_cycles = 0;
        @(posedge clk);
        while (pending_results != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/ggbs_pkg.sv
design/ggbs_req_if.sv
design/ggbs_res_if.sv
design/ggbs_ram.sv
design/ggbs_ctrl.sv
design/ggbs_datapath.sv
design/geo_grid_bilinear_sampler_unit.sv
design/ggbs_checker.sv
bench/ggbs_scoreboard.sv
bench/geo_grid_bilinear_sampler_unit_test.sv
